/* hw/rtl/wbtp_pkg.sv */
package wbtp_pkg;

    localparam int MAX_TASKS_DEF = 16;

    localparam int SLOT_W       = 4;
    localparam int WEIGHT_W     = 32;
    localparam int COUNT_W      = 32;
    localparam int HANDLE_W     = 64;
    localparam int PROD_W       = WEIGHT_W + COUNT_W;
    localparam int FRAC_W       = 16;
    localparam int KEY_W        = PROD_W - FRAC_W;
    localparam int TASK_COUNT_W = 5;

    localparam int S_TDATA_W = ((SLOT_W + WEIGHT_W + HANDLE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((HANDLE_W + SLOT_W + 7) / 8) * 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_PICK = 1'b1;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [COUNT_W-1:0]  count;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    // One scanned slot after the multiplier stage.
    typedef struct packed {
        logic                    valid;
        logic [TASK_COUNT_W-1:0] idx;
        logic [KEY_W-1:0]        key;
        entry_t                  entry;
    } key_beat_t;

endpackage

/* hw/rtl/wbtp_table.sv */
module wbtp_table #(
    parameter int MAX_TASKS = wbtp_pkg::MAX_TASKS_DEF,
    parameter int ADDR_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  wbtp_pkg::entry_t      wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output wbtp_pkg::entry_t      rd_data
);

    wbtp_pkg::entry_t mem [MAX_TASKS];
    wbtp_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/wbtp_key.sv */
module wbtp_key (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    input  logic [wbtp_pkg::TASK_COUNT_W-1:0]    in_idx,
    input  wbtp_pkg::entry_t                     in_entry,
    output wbtp_pkg::key_beat_t                  out_beat
);

    logic [wbtp_pkg::PROD_W-1:0] prod;
    wbtp_pkg::key_beat_t         beat_reg;

    // Exact Q16.16 times integer product; the key drops the fraction bits.
    assign prod = wbtp_pkg::PROD_W'(in_entry.weight) * wbtp_pkg::PROD_W'(in_entry.count);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg.valid <= 1'b0;
        end else begin
            beat_reg.valid <= in_valid;
        end
        beat_reg.idx   <= in_idx;
        beat_reg.key   <= prod[wbtp_pkg::PROD_W-1:wbtp_pkg::FRAC_W];
        beat_reg.entry <= in_entry;
    end

    assign out_beat = beat_reg;

endmodule

/* hw/rtl/weighted_beatty_task_picker.sv */
// Weighted task picker. The input stream carries load and pick words: s_tuser
// selects the operation, s_tdata carries slot, weight and handle. A load word
// writes one table slot and sets its service count to one; it gives no output.
// A pick word scans the slots below task_count, at most MAX_TASKS, one table read a cycle,
// multiplies weight by count and keeps the first slot with the smallest key.
// The winner's count is advanced and written back, and one output word gives
// its handle and slot, with m_tuser flagging a nonzero handle.
// A load is handled in the idle state. A pick reads the active slots one a cycle
// through the table read port, then passes the read register, the multiplier
// stage, write-back and hand-off to the output register; a pick with task_count
// zero goes straight to the output register. One word is in work at a time.
// The output word sits in a register, so a new input word is taken while the
// result waits; a pick that finishes while the receiver stalls holds until the
// output register frees. Reset clears task_count and all control state; table
// contents are undefined until loaded. cfg_wr_en writes task_count.
module weighted_beatty_task_picker #(
    parameter int MAX_TASKS = wbtp_pkg::MAX_TASKS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [wbtp_pkg::TASK_COUNT_W-1:0]   cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // slot [3:0], weight [35:4], task_handle [99:36], zero fill
    input  logic [wbtp_pkg::S_TDATA_W-1:0]      s_tdata,
    // op [0]
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // chosen_handle [63:0], chosen_slot [67:64], zero fill
    output logic [wbtp_pkg::M_TDATA_W-1:0]      m_tdata,
    // has_task [0]
    output logic                                m_tuser
);

    localparam int ADDR_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int TCW    = wbtp_pkg::TASK_COUNT_W;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_SCAN    = 4'b0010,
        ST_WRITE   = 4'b0100,
        ST_DELIVER = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [TCW-1:0] task_count_reg;
    logic [TCW-1:0] active;

    logic [wbtp_pkg::SLOT_W-1:0]   in_slot;
    logic [wbtp_pkg::WEIGHT_W-1:0] in_weight;
    logic [wbtp_pkg::HANDLE_W-1:0] in_handle;
    logic                          in_accept;

    logic [TCW-1:0] issue_idx_reg;
    logic           rd_valid_reg;
    logic [TCW-1:0] rd_idx_reg;
    logic           issue;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    wbtp_pkg::entry_t    wr_data;
    wbtp_pkg::entry_t    rd_data;
    wbtp_pkg::key_beat_t beat;

    logic [TCW-1:0]            best_idx_reg;
    logic [wbtp_pkg::KEY_W-1:0] best_key_reg;
    wbtp_pkg::entry_t          best_entry_reg;
    logic [wbtp_pkg::COUNT_W-1:0] next_count;

    logic [wbtp_pkg::HANDLE_W-1:0] res_handle_reg;
    logic [wbtp_pkg::SLOT_W-1:0]   res_slot_reg;
    logic                          res_has_reg;

    logic                          m_tvalid_reg;
    logic [wbtp_pkg::HANDLE_W-1:0] m_handle_reg;
    logic [wbtp_pkg::SLOT_W-1:0]   m_slot_reg;
    logic                          m_has_reg;
    logic                          out_free;

    assign in_slot   = s_tdata[wbtp_pkg::SLOT_W-1:0];
    assign in_weight = s_tdata[wbtp_pkg::SLOT_W +: wbtp_pkg::WEIGHT_W];
    assign in_handle = s_tdata[wbtp_pkg::SLOT_W + wbtp_pkg::WEIGHT_W +: wbtp_pkg::HANDLE_W];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        if (int'(task_count_reg) > MAX_TASKS) begin
            active = TCW'(MAX_TASKS);
        end else begin
            active = task_count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            task_count_reg <= '0;
        end else if (cfg_wr_en) begin
            task_count_reg <= cfg_wr_data;
        end
    end

    assign issue = (state_reg == ST_SCAN) && (issue_idx_reg < active);

    always_comb begin
        if (best_entry_reg.count != wbtp_pkg::COUNT_MAX) begin
            next_count = best_entry_reg.count + wbtp_pkg::COUNT_ONE;
        end else begin
            next_count = best_entry_reg.count;
        end
    end

    // The table has one write port, shared by loads and the count write-back.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = ADDR_W'(in_slot);
        wr_data.weight = in_weight;
        wr_data.count  = wbtp_pkg::COUNT_ONE;
        wr_data.handle = in_handle;
        if (state_reg == ST_WRITE) begin
            wr_en          = 1'b1;
            wr_addr        = ADDR_W'(best_idx_reg);
            wr_data.weight = best_entry_reg.weight;
            wr_data.count  = next_count;
            wr_data.handle = best_entry_reg.handle;
        end else if (in_accept && s_tuser == wbtp_pkg::OP_LOAD
                     && int'(in_slot) < MAX_TASKS) begin
            wr_en = 1'b1;
        end
    end

    wbtp_table #(
        .MAX_TASKS (MAX_TASKS),
        .ADDR_W    (ADDR_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (issue),
        .rd_addr (ADDR_W'(issue_idx_reg)),
        .rd_data (rd_data)
    );

    wbtp_key u_key (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (rd_valid_reg),
        .in_idx   (rd_idx_reg),
        .in_entry (rd_data),
        .out_beat (beat)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept && s_tuser == wbtp_pkg::OP_PICK) begin
                    if (active == '0) begin
                        state_next = ST_DELIVER;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (beat.valid && beat.idx == active - TCW'(1)) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                state_next = ST_DELIVER;
            end
            ST_DELIVER: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            issue_idx_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= issue;
            if (in_accept) begin
                issue_idx_reg <= '0;
            end else if (issue) begin
                issue_idx_reg <= issue_idx_reg + TCW'(1);
            end
        end
        rd_idx_reg <= issue_idx_reg;
    end

    // The first slot always seeds the search; later ones win only when strictly smaller.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_SCAN && beat.valid
            && (beat.idx == '0 || beat.key < best_key_reg)) begin
            best_idx_reg   <= beat.idx;
            best_key_reg   <= beat.key;
            best_entry_reg <= beat.entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            res_handle_reg <= '0;
            res_slot_reg   <= '0;
            res_has_reg    <= 1'b0;
        end else if (state_reg == ST_WRITE) begin
            res_handle_reg <= best_entry_reg.handle;
            res_slot_reg   <= best_idx_reg[wbtp_pkg::SLOT_W-1:0];
            res_has_reg    <= (best_entry_reg.handle != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_DELIVER && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (state_reg == ST_DELIVER && out_free) begin
            m_handle_reg <= res_handle_reg;
            m_slot_reg   <= res_slot_reg;
            m_has_reg    <= res_has_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = wbtp_pkg::M_TDATA_W'({m_slot_reg, m_handle_reg});
    assign m_tuser  = m_has_reg;

endmodule

/* test/task_pick_checker.sv */
module task_pick_checker
    import wbtp_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [TASK_COUNT_W-1:0] cfg_wr_data,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    // slot [3:0], weight [35:4], task_handle [99:36], zero fill
    input  logic [S_TDATA_W-1:0]    s_tdata,
    // op [0]
    input  logic                    s_tuser,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    // chosen_handle [63:0], chosen_slot [67:64], zero fill
    input  logic [M_TDATA_W-1:0]    m_tdata,
    // has_task [0]
    input  logic                    m_tuser,
    output int                      fail_count,
    output int                      pending,
    output int                      checked
);

    localparam int MAX_PRINTED = 30;

    typedef struct packed {
        logic [HANDLE_W-1:0] chosen_handle;
        logic [SLOT_W-1:0]   chosen_slot;
        logic                has_task;
    } pick_result_t;

    logic [WEIGHT_W-1:0]     weight_tbl [MAX_TASKS_DEF];
    logic [HANDLE_W-1:0]     handle_tbl [MAX_TASKS_DEF];
    logic [COUNT_W-1:0]      count_tbl  [MAX_TASKS_DEF];
    logic [TASK_COUNT_W-1:0] task_setting;
    pick_result_t            expected_picks [$];
    int                      mismatches = 0;
    int                      results_checked = 0;

    task automatic report_mismatch(input string what, input logic [HANDLE_W-1:0] got,
                                   input logic [HANDLE_W-1:0] want);
        if (mismatches < MAX_PRINTED)
            $display("MISMATCH at result %0d, %s: got %h, expected %h",
                     results_checked, what, got, want);
        mismatches++;
    endtask

    // floor(weight * count) with the weight in Q16.16, taken over the full product.
    function automatic logic [KEY_W-1:0] service_key(input int unsigned idx);
        logic [PROD_W-1:0] prod;
        prod = {{COUNT_W{1'b0}}, weight_tbl[idx]} * {{WEIGHT_W{1'b0}}, count_tbl[idx]};
        return prod[PROD_W-1:FRAC_W];
    endfunction

    // Chooses the first slot with the smallest key and advances its count.
    function automatic pick_result_t pick_next_task();
        pick_result_t     res;
        int unsigned      active;
        int unsigned      best;
        logic [KEY_W-1:0] best_key;
        logic [KEY_W-1:0] cur_key;
        res = '0;
        active = (task_setting > MAX_TASKS_DEF) ? MAX_TASKS_DEF : task_setting;
        if (active == 0)
            return res;
        best = 0;
        best_key = service_key(0);
        for (int unsigned i = 1; i < active; i++) begin
            cur_key = service_key(i);
            if (cur_key < best_key) begin
                best_key = cur_key;
                best = i;
            end
        end
        if (count_tbl[best] != COUNT_MAX)
            count_tbl[best] = count_tbl[best] + COUNT_ONE;
        res.chosen_handle = handle_tbl[best];
        res.chosen_slot   = SLOT_W'(best);
        res.has_task      = (handle_tbl[best] != '0);
        return res;
    endfunction

    always @(posedge aclk) begin : channel_watch
        pick_result_t        want;
        logic [SLOT_W-1:0]   load_slot;
        logic [HANDLE_W-1:0] got_handle;
        logic [SLOT_W-1:0]   got_slot;
        if (!aresetn) begin
            task_setting = '0;
            expected_picks.delete();
        end else begin
            if (cfg_wr_en)
                task_setting = cfg_wr_data;
            if (s_tvalid && s_tready) begin
                if (s_tuser == OP_LOAD) begin
                    load_slot = s_tdata[SLOT_W-1:0];
                    if (load_slot < MAX_TASKS_DEF) begin
                        weight_tbl[load_slot] = s_tdata[SLOT_W +: WEIGHT_W];
                        handle_tbl[load_slot] = s_tdata[SLOT_W + WEIGHT_W +: HANDLE_W];
                        count_tbl[load_slot]  = COUNT_ONE;
                    end
                end else begin
                    expected_picks.push_back(pick_next_task());
                end
            end
            if (m_tvalid && m_tready) begin
                got_handle = m_tdata[HANDLE_W-1:0];
                got_slot   = m_tdata[HANDLE_W +: SLOT_W];
                if (expected_picks.size() == 0) begin
                    report_mismatch("result word with nothing expected", got_handle, '0);
                end else begin
                    want = expected_picks.pop_front();
                    if (got_handle !== want.chosen_handle)
                        report_mismatch("chosen_handle", got_handle, want.chosen_handle);
                    if (got_slot !== want.chosen_slot)
                        report_mismatch("chosen_slot", HANDLE_W'(got_slot),
                                        HANDLE_W'(want.chosen_slot));
                    if (m_tuser !== want.has_task)
                        report_mismatch("has_task", HANDLE_W'(m_tuser), HANDLE_W'(want.has_task));
                end
                results_checked++;
            end
        end
        fail_count <= mismatches;
        pending    <= expected_picks.size();
        checked    <= results_checked;
    end

endmodule

/* test/testbench.sv */
module testbench;
    import wbtp_pkg::*;

    localparam int RANDOM_WORDS = 650;
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE       = 40;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int FILL_W       = S_TDATA_W - (SLOT_W + WEIGHT_W + HANDLE_W);

    logic                    aclk;
    logic                    aresetn      = 1'b0;
    logic                    cfg_wr_en    = 1'b0;
    logic [TASK_COUNT_W-1:0] cfg_wr_data  = '0;
    logic                    s_tvalid     = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata      = '0;
    logic                    s_tuser      = OP_LOAD;
    logic                    m_tvalid;
    logic                    m_tready     = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    m_tuser;
    logic                    hold_request = 1'b0;

    int fail_count;
    int pending;
    int checked;
    int loads_sent    = 0;
    int picks_sent    = 0;
    int settings_used = 0;
    bit eager         = 1'b0;

    weighted_beatty_task_picker dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    task_pick_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .pending     (pending),
        .checked     (checked)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Offers one word and returns at the edge where it is taken, then maybe idles.
    task automatic issue_word(input logic op, input logic [SLOT_W-1:0] slot,
                              input logic [WEIGHT_W-1:0] weight,
                              input logic [HANDLE_W-1:0] handle);
        int unsigned roll;
        int unsigned gap;
        s_tuser  <= op;
        s_tdata  <= {{FILL_W{1'b0}}, handle, weight, slot};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (op == OP_LOAD)
            loads_sent++;
        else
            picks_sent++;
        roll = $urandom_range(99);
        if (eager || roll < 70)
            gap = 0;
        else if (roll < 93)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(15, 60);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // The register may only change once every pick has drained; a trailing load
    // gives no result, so the further SETTLE wait covers it as well.
    task automatic set_task_count(input logic [TASK_COUNT_W-1:0] value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic issue_random_word();
        int unsigned         roll;
        logic                op;
        logic [WEIGHT_W-1:0] weight;
        logic [HANDLE_W-1:0] handle;
        op = ($urandom_range(99) < 70) ? OP_PICK : OP_LOAD;
        roll = $urandom_range(99);
        if (roll < 5)
            weight = '0;
        else if (roll < 12)
            weight = '1;
        else if (roll < 60)
            weight = $urandom_range(32'h0000_8000, 32'h0004_0000);
        else
            weight = $urandom;
        roll = $urandom_range(99);
        if (roll < 8)
            handle = '0;
        else if (roll < 14)
            handle = '1;
        else
            handle = {$urandom, $urandom};
        issue_word(op, SLOT_W'($urandom_range(15)), weight, handle);
    endtask

    // Receiver: stretches of steady acceptance, short stalls, now and then a long one.
    initial begin
        int unsigned roll;
        int unsigned span;
        bit          hold_done;
        hold_done = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                span = LONG_HOLD;
            end else begin
                roll = $urandom_range(99);
                if (roll < 55) begin
                    m_tready <= 1'b1;
                    span = $urandom_range(1, 30);
                end else if (roll < 92) begin
                    m_tready <= 1'b0;
                    span = $urandom_range(1, 3);
                end else begin
                    m_tready <= 1'b0;
                    span = $urandom_range(15, 60);
                end
            end
            repeat (span) @(posedge aclk);
        end
    end

    initial begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int                      random_sent;
        int                      phase;
        int                      phase_words;
        logic [TASK_COUNT_W-1:0] setting;
        random_sent = 0;
        phase = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // With no tasks in use a pick still answers, empty.
        issue_word(OP_PICK, '1, '1, '1);
        issue_word(OP_PICK, '0, '0, '0);

        // Fill every slot so that no later pick scans an unloaded one.
        issue_word(OP_LOAD, 4'd0, '1, '1);
        issue_word(OP_LOAD, 4'd1, 32'h0001_0000, '0);
        for (int s = 2; s < MAX_TASKS_DEF; s++)
            issue_word(OP_LOAD, SLOT_W'(s), 32'h0001_0000, {$urandom, $urandom});

        set_task_count(TASK_COUNT_W'(1));
        issue_word(OP_PICK, '0, '0, '0);
        issue_word(OP_PICK, '0, '0, '0);

        // Equal keys: the lowest slot wins, the zero handle in slot 1 included.
        set_task_count(TASK_COUNT_W'(MAX_TASKS_DEF));
        repeat (3) issue_word(OP_PICK, '0, '0, '0);

        // A setting above the table size scans the whole table.
        set_task_count('1);
        repeat (2) issue_word(OP_PICK, '1, '1, '1);

        // A zero weight keeps its slot in front until it is reloaded.
        issue_word(OP_LOAD, 4'd9, '0, '1);
        repeat (2) issue_word(OP_PICK, '0, '0, '0);
        issue_word(OP_LOAD, 4'd9, '1, {$urandom, $urandom});
        issue_word(OP_PICK, '0, '0, '0);

        while (random_sent < RANDOM_WORDS) begin
            case (phase % 9)
                0, 5, 8: setting = TASK_COUNT_W'(MAX_TASKS_DEF);
                1:       setting = '0;
                2:       setting = '1;
                3:       setting = TASK_COUNT_W'(1);
                6:       setting = TASK_COUNT_W'($urandom_range(MAX_TASKS_DEF + 1, 30));
                default: setting = TASK_COUNT_W'($urandom_range(2, MAX_TASKS_DEF - 1));
            endcase
            set_task_count(setting);
            eager = ($urandom_range(3) == 0);
            // Back up the output during one of the full-table phases.
            if (phase == 2)
                hold_request <= 1'b1;
            phase_words = $urandom_range(60, 85);
            repeat (phase_words) begin
                issue_random_word();
                random_sent++;
            end
            phase++;
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        $display("Sent %0d load words and %0d pick words under %0d task_count settings.",
                 loads_sent, picks_sent, settings_used);
        $display("Checked %0d result words, including one long output stall.", checked);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
